[rtl/bfatsp_pkg.sv]
package bfatsp_pkg;

  localparam int MAX_CITIES_DEF = 8;
  localparam int COST_BITS_DEF  = 16;

  localparam int CITY_W     = 3;
  localparam int COUNT_W    = 4;
  localparam int EDGE_IN_W  = 16;
  localparam int TOTAL_W    = 20;
  localparam int OUT_COST_W = 19;
  localparam int CFG_W      = 4;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_CITY_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOME_CITY  = 1'd1;

  localparam logic [COUNT_W-1:0]    COUNT_RESET = 4'd4;
  localparam logic [CITY_W-1:0]     HOME_RESET  = 3'd0;
  localparam logic [TOTAL_W-1:0]    TOTAL_MAX   = '1;
  localparam logic [OUT_COST_W-1:0] OUT_MAX     = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DRAIN,
    ST_CMP,
    ST_ADV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic start;    // latch count/home, load first ordering
    logic issue;    // read next edge of current tour
    logic compare;  // keep tour if cheaper
    logic advance;  // step to next ordering
    logic emit;     // load output register
  } cmd_t;

  typedef struct packed {
    logic last_edge;
    logic more;
    logic emit_last;
    logic out_free;
  } sts_t;

endpackage

[rtl/brute_force_atsp_solver_unit.sv]
// Loading: one cost word per cycle, no stall while idle.
// Search after the word marked load_done: every ordering of the n-1
// non-home cities is summed, compared and stepped; n is the clamped count.
// Then n+1 result words, one per cycle while out_stall is low.
// Reset: rst is synchronous, active high; clears control and config
// registers. The cost memory holds anything until written.
module brute_force_atsp_solver_unit #(
  parameter int MAX_CITIES = bfatsp_pkg::MAX_CITIES_DEF,
  parameter int COST_BITS  = bfatsp_pkg::COST_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // config port
  input  logic                                cfg_we,
  input  logic [bfatsp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bfatsp_pkg::CFG_W-1:0]        cfg_data,
  // input words: one cost table entry each
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bfatsp_pkg::CITY_W-1:0]       from_city,
  input  logic [bfatsp_pkg::CITY_W-1:0]       to_city,
  input  logic [bfatsp_pkg::EDGE_IN_W-1:0]    edge_cost,
  input  logic                                load_done,
  // result words: best tour, home first and last
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bfatsp_pkg::CITY_W-1:0]       route_city,
  output logic [bfatsp_pkg::OUT_COST_W-1:0]   tour_cost,
  output logic                                route_end
);

  bfatsp_pkg::cmd_t cmd;
  bfatsp_pkg::sts_t sts;
  logic             in_accept;

  // input is held off for the whole search and emit phase
  assign in_accept = in_valid && !in_stall;

  bfatsp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .load_done (load_done),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (in_stall)
  );

  // datapath: cost memory, ordering registers, accumulator, best tour,
  // output register
  bfatsp_dpath #(
    .MAX_CITIES (MAX_CITIES),
    .COST_BITS  (COST_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_accept  (in_accept),
    .from_city  (from_city),
    .to_city    (to_city),
    .edge_cost  (edge_cost),
    .cmd        (cmd),
    .sts        (sts),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .route_city (route_city),
    .tour_cost  (tour_cost),
    .route_end  (route_end)
  );

endmodule

[rtl/bfatsp_ctrl.sv]
module bfatsp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_accept,
  input  logic              load_done,
  input  bfatsp_pkg::sts_t  sts,
  output bfatsp_pkg::cmd_t  cmd,
  output logic              busy
);

  bfatsp_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfatsp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bfatsp_pkg::ST_IDLE: begin
        if (in_accept && load_done) state_next = bfatsp_pkg::ST_SUM;
      end
      bfatsp_pkg::ST_SUM: begin
        if (sts.last_edge) state_next = bfatsp_pkg::ST_DRAIN;
      end
      bfatsp_pkg::ST_DRAIN: state_next = bfatsp_pkg::ST_CMP;
      bfatsp_pkg::ST_CMP:   state_next = bfatsp_pkg::ST_ADV;
      bfatsp_pkg::ST_ADV: begin
        state_next = sts.more ? bfatsp_pkg::ST_SUM : bfatsp_pkg::ST_EMIT;
      end
      bfatsp_pkg::ST_EMIT: begin
        if (sts.out_free && sts.emit_last) state_next = bfatsp_pkg::ST_IDLE;
      end
      default: state_next = bfatsp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state != bfatsp_pkg::ST_IDLE);
    unique case (state)
      bfatsp_pkg::ST_IDLE: cmd.start   = in_accept && load_done;
      bfatsp_pkg::ST_SUM:  cmd.issue   = 1'b1;
      bfatsp_pkg::ST_CMP:  cmd.compare = 1'b1;
      bfatsp_pkg::ST_ADV:  cmd.advance = 1'b1;
      bfatsp_pkg::ST_EMIT: cmd.emit    = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

[rtl/bfatsp_dpath.sv]
module bfatsp_dpath #(
  parameter int MAX_CITIES = bfatsp_pkg::MAX_CITIES_DEF,
  parameter int COST_BITS  = bfatsp_pkg::COST_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bfatsp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bfatsp_pkg::CFG_W-1:0]        cfg_data,
  input  logic                                in_accept,
  input  logic [bfatsp_pkg::CITY_W-1:0]       from_city,
  input  logic [bfatsp_pkg::CITY_W-1:0]       to_city,
  input  logic [bfatsp_pkg::EDGE_IN_W-1:0]    edge_cost,
  input  bfatsp_pkg::cmd_t                    cmd,
  output bfatsp_pkg::sts_t                    sts,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic [bfatsp_pkg::CITY_W-1:0]       route_city,
  output logic [bfatsp_pkg::OUT_COST_W-1:0]   tour_cost,
  output logic                                route_end
);

  localparam int VW    = MAX_CITIES - 1;
  localparam int DEPTH = MAX_CITIES * MAX_CITIES;
  localparam int AW    = $clog2(DEPTH);
  localparam int EW    = $clog2(MAX_CITIES + 1);
  localparam int CW    = bfatsp_pkg::COUNT_W;
  localparam int TW    = bfatsp_pkg::TOTAL_W;
  localparam int SW    = ((COST_BITS > TW) ? COST_BITS : TW) + 1;
  localparam int XW    = bfatsp_pkg::EDGE_IN_W + 32;

  typedef logic [bfatsp_pkg::CITY_W-1:0] city_t;

  logic [COST_BITS-1:0] mem [DEPTH];
  logic [COST_BITS-1:0] rdata;
  logic                 rd_valid;

  logic [CW-1:0] city_count, n_eff, n_c, k;
  city_t         home_city, home_eff, home_c;
  city_t         vo [VW];
  city_t         vo_init [VW];
  city_t         vo_next [VW];
  city_t         best_route [VW];
  logic [TW-1:0] best_total, running_total, sum_sat;
  logic          found;
  logic [EW-1:0] edge_idx, emit_idx;
  city_t         from_sel, to_sel, emit_city;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [XW-1:0] cost_ext;
  logic [SW-1:0] sum;
  logic          has_piv;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      city_count <= bfatsp_pkg::COUNT_RESET;
      home_city  <= bfatsp_pkg::HOME_RESET;
    end else if (cfg_we) begin
      if (cfg_index == bfatsp_pkg::CFG_CITY_COUNT) city_count <= cfg_data;
      if (cfg_index == bfatsp_pkg::CFG_HOME_CITY)
        home_city <= cfg_data[bfatsp_pkg::CITY_W-1:0];
    end
  end

  always_comb begin
    if (city_count < CW'(2))               n_c = CW'(2);
    else if (city_count > CW'(MAX_CITIES)) n_c = CW'(MAX_CITIES);
    else                                   n_c = city_count;
    home_c = (32'(home_city) >= 32'(n_c)) ? city_t'(n_c - CW'(1)) : home_city;
    for (int x = 0; x < VW; x++) begin
      vo_init[x] = (32'(x) < 32'(home_c)) ? city_t'(x) : city_t'(x + 1);
    end
  end

  assign k = n_eff - CW'(1);

  // cost memory
  assign cost_ext = XW'(edge_cost);
  assign wr_addr  = AW'(32'(from_city) * MAX_CITIES + 32'(to_city));

  always_comb begin
    from_sel = home_eff;
    to_sel   = home_eff;
    for (int x = 0; x < VW; x++) begin
      if (edge_idx == EW'(x + 1)) from_sel = vo[x];
      if (edge_idx == EW'(x) && EW'(k) != edge_idx) to_sel = vo[x];
    end
  end

  assign rd_addr = AW'(32'(from_sel) * MAX_CITIES + 32'(to_sel));

  always_ff @(posedge clk) begin
    if (in_accept && 32'(from_city) < MAX_CITIES && 32'(to_city) < MAX_CITIES) begin
      mem[wr_addr] <= cost_ext[COST_BITS-1:0];
    end
    rdata <= mem[rd_addr];
  end

  // next lexicographic ordering over the first k entries
  always_comb begin
    int    kk, piv, jj;
    city_t pv, pj;
    city_t sw [VW];
    kk      = int'(k);
    piv     = 0;
    jj      = 0;
    pv      = '0;
    pj      = '0;
    for (int x = 1; x < VW; x++) begin
      if (x < kk && vo[x-1] < vo[x]) piv = x;
    end
    has_piv = (piv > 0);
    for (int x = 0; x < VW; x++) begin
      if (x == piv - 1) pv = vo[x];
    end
    for (int x = 0; x < VW; x++) begin
      if (x >= piv && x < kk && vo[x] > pv) jj = x;
    end
    for (int x = 0; x < VW; x++) begin
      if (x == jj) pj = vo[x];
    end
    for (int x = 0; x < VW; x++) begin
      sw[x] = vo[x];
      if (has_piv && x == piv - 1) sw[x] = pj;
      if (has_piv && x == jj)      sw[x] = pv;
    end
    for (int x = 0; x < VW; x++) begin
      vo_next[x] = sw[x];
      for (int y = 0; y < VW; y++) begin
        if (x >= piv && x < kk && y == piv + kk - 1 - x) vo_next[x] = sw[y];
      end
    end
  end

  assign sum     = SW'(running_total) + SW'(rdata);
  assign sum_sat = (sum > SW'(bfatsp_pkg::TOTAL_MAX)) ? bfatsp_pkg::TOTAL_MAX : sum[TW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      found    <= 1'b0;
      edge_idx <= '0;
      emit_idx <= '0;
    end else begin
      rd_valid <= cmd.issue;
      if (cmd.start) begin
        found    <= 1'b0;
        edge_idx <= '0;
        emit_idx <= '0;
      end
      if (cmd.issue) edge_idx <= edge_idx + EW'(1);
      if (cmd.compare) found <= 1'b1;
      if (cmd.advance) begin
        edge_idx <= '0;
        emit_idx <= '0;
      end
      if (cmd.emit) emit_idx <= emit_idx + EW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      n_eff         <= n_c;
      home_eff      <= home_c;
      vo            <= vo_init;
      best_total    <= bfatsp_pkg::TOTAL_MAX;
      running_total <= '0;
    end
    if (rd_valid) running_total <= sum_sat;
    if (cmd.compare && (!found || running_total < best_total)) begin
      best_total <= running_total;
      best_route <= vo;
    end
    if (cmd.advance) begin
      vo            <= vo_next;
      running_total <= '0;
    end
  end

  // result select
  always_comb begin
    emit_city = home_eff;
    for (int x = 0; x < VW; x++) begin
      if (emit_idx == EW'(x + 1) && 32'(emit_idx) <= 32'(k)) emit_city = best_route[x];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      route_city <= emit_city;
      route_end  <= sts.emit_last;
      tour_cost  <= (best_total > TW'(bfatsp_pkg::OUT_MAX)) ? bfatsp_pkg::OUT_MAX
                                                            : best_total[bfatsp_pkg::OUT_COST_W-1:0];
    end
  end

  assign sts.last_edge = (edge_idx == EW'(k));
  assign sts.more      = has_piv;
  assign sts.emit_last = (32'(emit_idx) == 32'(k) + 1);
  assign sts.out_free  = !out_valid || !out_stall;

endmodule

[rtl/bfatsp_checker.sv]
module bfatsp_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              load_done,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [bfatsp_pkg::CITY_W-1:0]     route_city,
  input logic                              route_end
);

  // a started search blocks input on the next cycle
  a_start_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && load_done |=> in_stall)
    else $error("input not held off after load_done");

  // no result shows while loading is open
  a_no_out_idle: assert property (@(posedge clk) disable iff (rst)
    !in_stall && $past(!in_stall) && !$past(rst) |-> !out_valid || $past(out_valid))
    else $error("result appeared while idle");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(route_city) && $stable(route_end))
    else $error("stalled result changed");

endmodule

bind brute_force_atsp_solver_unit bfatsp_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .load_done  (load_done),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .route_city (route_city),
  .route_end  (route_end)
);

[tb/tb_brute_force_atsp_solver_unit.sv]
`timescale 1ns / 100ps

module tb_brute_force_atsp_solver_unit;

  localparam int LIMIT = 3000000;  // cycles; two full 8-city searches fit many times over

  typedef logic [bfatsp_pkg::CITY_W-1:0] tb_city_t;

  // one result word of the best tour
  typedef struct {
    logic [bfatsp_pkg::CITY_W-1:0]     city;
    logic [bfatsp_pkg::OUT_COST_W-1:0] cost;
    logic                              last;
  } stop_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [bfatsp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bfatsp_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [bfatsp_pkg::CITY_W-1:0] from_city = '0;
  logic [bfatsp_pkg::CITY_W-1:0] to_city = '0;
  logic [bfatsp_pkg::EDGE_IN_W-1:0] edge_cost = '0;
  logic load_done = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [bfatsp_pkg::CITY_W-1:0] route_city;
  logic [bfatsp_pkg::OUT_COST_W-1:0] tour_cost;
  logic route_end;

  brute_force_atsp_solver_unit dut (.*);

  // TB copy of the block's state
  logic [bfatsp_pkg::EDGE_IN_W-1:0] cost_tab [8][8];
  logic [bfatsp_pkg::COUNT_W-1:0] count_reg = bfatsp_pkg::COUNT_RESET;
  logic [bfatsp_pkg::CITY_W-1:0] home_reg = bfatsp_pkg::HOME_RESET;
  stop_t route_q[$];

  int errors = 0;
  int cyc = 0;
  int words_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int hold_left = 0;

  initial forever #6 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Full search over orderings of the non-home cities, first strictly
  // cheapest tour kept; queues n+1 expected result words.
  function automatic void solve_tour();
    int n, home, k, i, j, lo, hi, t, cur;
    int ord[7];
    int best_ord[7];
    logic [bfatsp_pkg::TOTAL_W:0] sum;
    logic [bfatsp_pkg::TOTAL_W-1:0] run, best;
    logic [bfatsp_pkg::OUT_COST_W-1:0] oc;
    bit found;
    stop_t s;
    n = int'(count_reg);
    if (n < 2) n = 2;
    if (n > 8) n = 8;
    home = int'(home_reg);
    if (home >= n) home = n - 1;
    k = n - 1;
    j = 0;
    for (i = 0; i < n; i++) if (i != home) ord[j++] = i;
    found = 0;
    best = bfatsp_pkg::TOTAL_MAX;
    forever begin
      cur = home;
      run = '0;
      for (i = 0; i <= k; i++) begin
        t = (i < k) ? ord[i] : home;
        sum = run + cost_tab[cur][t];
        run = (sum > bfatsp_pkg::TOTAL_MAX) ? bfatsp_pkg::TOTAL_MAX
                                            : sum[bfatsp_pkg::TOTAL_W-1:0];
        cur = t;
      end
      if (!found || run < best) begin
        found = 1;
        best = run;
        best_ord = ord;
      end
      // next lexicographic ordering
      if (k < 2) break;
      i = k - 1;
      while (i > 0 && ord[i-1] >= ord[i]) i--;
      if (i == 0) break;
      j = k - 1;
      while (ord[j] <= ord[i-1]) j--;
      t = ord[i-1]; ord[i-1] = ord[j]; ord[j] = t;
      lo = i; hi = k - 1;
      while (lo < hi) begin
        t = ord[lo]; ord[lo] = ord[hi]; ord[hi] = t;
        lo++; hi--;
      end
    end
    oc = (best > bfatsp_pkg::OUT_MAX) ? bfatsp_pkg::OUT_MAX
                                      : best[bfatsp_pkg::OUT_COST_W-1:0];
    s.cost = oc;
    s.city = tb_city_t'(home); s.last = 1'b0;
    route_q = {route_q, s};
    for (i = 0; i < k; i++) begin
      s.city = tb_city_t'(best_ord[i]);
      route_q = {route_q, s};
    end
    s.city = tb_city_t'(home); s.last = 1'b1;
    route_q = {route_q, s};
  endfunction

  // result checker and receiver stall driver
  always @(posedge clk) begin
    stop_t e;
    if (!rst && out_valid && !out_stall) begin
      if (route_q.size() == 0) begin
        $display("%0t: unexpected word city=%0d cost=%0d end=%0b", $time,
                 route_city, tour_cost, route_end);
        errors++;
      end else begin
        e = route_q.pop_front();
        if (route_city !== e.city) begin
          $display("%0t: route_city exp %0d got %0d", $time, e.city, route_city);
          errors++;
        end
        if (tour_cost !== e.cost) begin
          $display("%0t: tour_cost exp %0d got %0d", $time, e.cost, tour_cost);
          errors++;
        end
        if (route_end !== e.last) begin
          $display("%0t: route_end exp %0b got %0b", $time, e.last, route_end);
          errors++;
        end
      end
    end
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Offer one word, with random sender gaps; leaves in_valid high.
  task automatic send_word(input logic [2:0] f, input logic [2:0] t,
                           input logic [15:0] c, input logic d);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    from_city <= f;
    to_city <= t;
    edge_cost <= c;
    load_done <= d;
    do @(posedge clk); while (in_stall);
    cost_tab[f][t] = c;
    words_sent++;
    if (d) solve_tour();
  endtask

  // drop valid, wait for every expected word, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (route_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // only called while idle (after drain)
  task automatic write_reg(input logic [bfatsp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bfatsp_pkg::CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == bfatsp_pkg::CFG_CITY_COUNT) count_reg = val;
    else home_reg = val[bfatsp_pkg::CITY_W-1:0];
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_cost();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'd100;  // shared value breeds ties
      default: return 16'($urandom);
    endcase
  endfunction

  // reset config is 4 cities, home 0: load the 4x4 block, all equal; extremes on
  // the last words make 1->2 dearest; tours avoiding it tie and the first must win
  task automatic test_tie_at_reset();
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        send_word(3'(i), 3'(j), 16'd7, 1'b0);
    send_word(3'd1, 3'd2, 16'hFFFF, 1'b0);
    send_word(3'd0, 3'd0, 16'h0000, 1'b1);
    drain();
  endtask

  // count below the range, home beyond the count, two- and three-city tours
  task automatic test_clamped_config();
    write_reg(bfatsp_pkg::CFG_CITY_COUNT, 4'd0);
    write_reg(bfatsp_pkg::CFG_HOME_CITY, 4'd7);
    send_word(3'd0, 3'd1, 16'd9, 1'b1);
    drain();
    write_reg(bfatsp_pkg::CFG_CITY_COUNT, 4'd2);
    write_reg(bfatsp_pkg::CFG_HOME_CITY, 4'd0);
    send_word(3'd1, 3'd0, 16'hFFFF, 1'b1);
    drain();
    write_reg(bfatsp_pkg::CFG_CITY_COUNT, 4'd3);
    write_reg(bfatsp_pkg::CFG_HOME_CITY, 4'd2);
    send_word(3'd2, 3'd0, 16'd1, 1'b1);
    drain();
  endtask

  // fill the whole 8x8 table, then the largest tours: count 8 and count
  // above the range, costs high enough to hit the upper sums
  task automatic test_full_table();
    for (int i = 0; i < 8; i++)
      for (int j = 0; j < 8; j++)
        send_word(3'(i), 3'(j), (i + j) % 3 == 0 ? 16'hFFFF : pick_cost(), 1'b0);
    drain();
    write_reg(bfatsp_pkg::CFG_CITY_COUNT, 4'd8);
    write_reg(bfatsp_pkg::CFG_HOME_CITY, 4'd5);
    send_word(3'd7, 3'd6, 16'hFFFF, 1'b1);
    drain();
    write_reg(bfatsp_pkg::CFG_CITY_COUNT, 4'd15);
    write_reg(bfatsp_pkg::CFG_HOME_CITY, 4'd0);
    send_word(3'd6, 3'd7, 16'd3, 1'b1);
    drain();
  endtask

  // a table update burst ending in load_done
  task automatic run_search();
    int m;
    m = $urandom_range(0, 10);
    for (int i = 0; i < m; i++)
      send_word(3'($urandom_range(7)), 3'($urandom_range(7)), pick_cost(), 1'b0);
    send_word(3'($urandom_range(7)), 3'($urandom_range(7)), pick_cost(), 1'b1);
  endtask

  // random sizes, mostly small; new config only once the block is idle
  task automatic test_random_tours(input int words);
    int stop_at;
    stop_at = words_sent + words;
    while (words_sent < stop_at) begin
      drain();
      write_reg(bfatsp_pkg::CFG_CITY_COUNT,
                ($urandom_range(19) == 0) ? 4'd7 : 4'($urandom_range(0, 6)));
      write_reg(bfatsp_pkg::CFG_HOME_CITY, 4'($urandom_range(7)));
      repeat ($urandom_range(1, 3)) run_search();
      // table noise with no search
      if ($urandom_range(3) == 0)
        send_word(3'($urandom_range(7)), 3'($urandom_range(7)), 16'($urandom), 1'b0);
    end
    drain();
  endtask

  // receiver holds off for a long stretch while searches keep coming, so
  // the output backs up and in_stall rises; then the sender waits for all
  task automatic test_backpressure();
    write_reg(bfatsp_pkg::CFG_CITY_COUNT, 4'd3);
    write_reg(bfatsp_pkg::CFG_HOME_CITY, 4'd1);
    hold_req = 400;
    for (int i = 0; i < 6; i++)
      send_word(3'($urandom_range(7)), 3'($urandom_range(7)), pick_cost(), 1'b1);
    drain();
  endtask

  initial begin
    for (int i = 0; i < 8; i++)
      for (int j = 0; j < 8; j++)
        cost_tab[i][j] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 29; recv_idle_pct = 73;
    test_tie_at_reset();
    test_clamped_config();
    test_full_table();
    test_backpressure();
    test_random_tours(55);
    send_idle_pct = 73; recv_idle_pct = 29;
    test_random_tours(55);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random_tours(55);

    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
